// File: hw/rtl/ray_cylinder_intersection_assert.svh
// assertion macros for the ray cylinder intersection block
`ifndef RAY_CYLINDER_INTERSECTION_ASSERT_SVH
`define RAY_CYLINDER_INTERSECTION_ASSERT_SVH

// clocked check, masked while reset is active
`define RCI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("check failed: lbl");

// clocked check that also holds through reset
`define RCI_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("check failed: lbl");

`endif

// File: hw/rtl/rci_pkg.sv
// shared constants, types and helper functions of the ray cylinder intersection
`timescale 1ns / 1ps
package rci_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam logic [30:0] RADIUS_RESET = 31'd65536;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;

    // horner divisors of the sine and cosine series
    localparam int NS = 6;
    localparam int NC = 7;
    localparam int KS [0:NS-1] = '{156, 110, 72, 42, 20, 6};
    localparam int KC [0:NC-1] = '{182, 132, 90, 56, 30, 12, 2};

    localparam int SQRT_BITS = 31;
    localparam int QUO_BITS = 34;

    // pipeline depth: fold, scale, square, series, sign fix
    localparam int SC_LAT = 3 + 2 * NC + 1;
    // input, sincos, four plane stages, root, three stages, divide, output
    localparam int LAT = 1 + SC_LAT + 4 + SQRT_BITS + 3 + QUO_BITS + 1;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [31:0] q30_t;

    // saturate to the signed 32-bit range
    function automatic q16_t sat32(input logic signed [39:0] v);
        q16_t r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // floor(v / 2^30 + 1/2)
    function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
        logic signed [63:0] a;
        a = (v + 64'sd536870912) >>> 30;
        return a[33:0];
    endfunction

endpackage

// File: hw/rtl/rci_horner_cell.sv
// one horner step of a sine or cosine series: t = 1 - ((x2*t)>>30)/K
`timescale 1ns / 1ps
module rci_horner_cell #(
    parameter int K = 2,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [30:0]       x2_i,
    input  logic [30:0]       t_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic [30:0]       x2_o,
    output logic [30:0]       t_o,
    output logic [SIDE_W-1:0] side_o
);
    import rci_pkg::*;

    // reciprocal of K, exact for products below 2^30
    localparam int S = 30 + $clog2(K);
    localparam logic [63:0] M64 = ((64'd1 << S) + 64'(K) - 64'd1) / 64'(K);
    localparam logic [30:0] M = M64[30:0];

    logic [61:0]       prod_a;
    logic [61:0]       prod_b;
    logic [61:0]       quo_b;
    logic [30:0]       p_reg;
    logic [30:0]       x2_a_reg;
    logic [SIDE_W-1:0] side_a_reg;
    logic [30:0]       x2_b_reg;
    logic [30:0]       t_b_reg;
    logic [SIDE_W-1:0] side_b_reg;

    assign prod_a = 62'(x2_i) * 62'(t_i);
    assign prod_b = 62'(p_reg) * 62'(M);
    assign quo_b  = prod_b >> S;

    // first half: product with x2, second half: divide and subtract from one
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg      <= prod_a[60:30];
            x2_a_reg   <= x2_i;
            side_a_reg <= side_i;
            t_b_reg    <= Q30_ONE - quo_b[30:0];
            x2_b_reg   <= x2_a_reg;
            side_b_reg <= side_a_reg;
        end
    end

    assign x2_o   = x2_b_reg;
    assign t_o    = t_b_reg;
    assign side_o = side_b_reg;

endmodule

// File: hw/rtl/rci_sincos.sv
// pipelined q30 sine and cosine of an angle given in 2^-32 turns
`timescale 1ns / 1ps
module rci_sincos #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [31:0]       turns,
    input  logic [SIDE_W-1:0] side_i,
    output rci_pkg::q30_t     sin_o,
    output rci_pkg::q30_t     cos_o,
    output logic [SIDE_W-1:0] side_o
);
    import rci_pkg::*;

    localparam int CW = SIDE_W + 3;

    logic [2:0]        o_a_reg;
    logic [29:0]       r_a_reg;
    logic [SIDE_W-1:0] side_a_reg;
    logic [62:0]       xprod;
    logic [2:0]        o_b_reg;
    logic [30:0]       x_b_reg;
    logic [SIDE_W-1:0] side_b_reg;
    logic [61:0]       x2prod;
    logic [2:0]        o_c_reg;
    logic [30:0]       x_c_reg;
    logic [30:0]       x2_c_reg;
    logic [SIDE_W-1:0] side_c_reg;

    logic [30:0]       c_x2 [0:NC];
    logic [30:0]       c_t [0:NC];
    logic [CW-1:0]     c_side [0:NC];
    logic [30:0]       s_x2 [0:NS];
    logic [30:0]       s_t [0:NS];
    logic [30:0]       s_x [0:NS];

    logic [61:0]       svprod;
    logic [30:0]       sv_reg;
    logic [30:0]       sv_dly_reg;
    logic [2:0]        o_f;
    logic [SIDE_W-1:0] side_f;
    logic [3:0]        o_inc;
    logic [30:0]       sv_f;
    logic [30:0]       cv_f;
    q30_t              sin_reg;
    q30_t              cos_reg;
    logic [SIDE_W-1:0] side_reg;

    // fold into the first octant
    always_ff @(posedge aclk) begin
        if (en) begin
            o_a_reg    <= turns[31:29];
            r_a_reg    <= turns[29] ? (30'h2000_0000 - {1'b0, turns[28:0]})
                                    : {1'b0, turns[28:0]};
            side_a_reg <= side_i;
        end
    end

    // octant residue to radians, then square
    assign xprod  = 63'(r_a_reg) * 63'(HALF_PI_Q32);
    assign x2prod = 62'(x_b_reg) * 62'(x_b_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            o_b_reg    <= o_a_reg;
            x_b_reg    <= xprod[62:32];
            side_b_reg <= side_a_reg;
            o_c_reg    <= o_b_reg;
            x_c_reg    <= x_b_reg;
            x2_c_reg   <= x2prod[60:30];
            side_c_reg <= side_b_reg;
        end
    end

    // cosine series chain
    assign c_x2[0]   = x2_c_reg;
    assign c_t[0]    = Q30_ONE;
    assign c_side[0] = {side_c_reg, o_c_reg};

    for (genvar g = 0; g < NC; g++) begin : g_cos
        rci_horner_cell #(.K(KC[g]), .SIDE_W(CW)) u_cell (
            .aclk   (aclk),
            .en     (en),
            .x2_i   (c_x2[g]),
            .t_i    (c_t[g]),
            .side_i (c_side[g]),
            .x2_o   (c_x2[g+1]),
            .t_o    (c_t[g+1]),
            .side_o (c_side[g+1])
        );
    end

    // sine series chain, carries x for the final product
    assign s_x2[0] = x2_c_reg;
    assign s_t[0]  = Q30_ONE;
    assign s_x[0]  = x_c_reg;

    for (genvar g = 0; g < NS; g++) begin : g_sin
        rci_horner_cell #(.K(KS[g]), .SIDE_W(31)) u_cell (
            .aclk   (aclk),
            .en     (en),
            .x2_i   (s_x2[g]),
            .t_i    (s_t[g]),
            .side_i (s_x[g]),
            .x2_o   (s_x2[g+1]),
            .t_o    (s_t[g+1]),
            .side_o (s_x[g+1])
        );
    end

    // sine = x * series, delayed to meet the longer cosine chain
    assign svprod = 62'(s_x[NS]) * 62'(s_t[NS]);

    always_ff @(posedge aclk) begin
        if (en) begin
            sv_reg     <= svprod[60:30];
            sv_dly_reg <= sv_reg;
        end
    end

    // octant symmetry: swap and signs
    assign {side_f, o_f} = c_side[NC];
    assign o_inc = {1'b0, o_f} + 4'd1;

    always_comb begin
        if (o_inc[1]) begin
            sv_f = c_t[NC];
            cv_f = sv_dly_reg;
        end else begin
            sv_f = sv_dly_reg;
            cv_f = c_t[NC];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg  <= o_f[2] ? -$signed({1'b0, sv_f}) : $signed({1'b0, sv_f});
            cos_reg  <= (o_f[2] ^ o_f[1]) ? -$signed({1'b0, cv_f})
                                          : $signed({1'b0, cv_f});
            side_reg <= side_f;
        end
    end

    assign sin_o  = sin_reg;
    assign cos_o  = cos_reg;
    assign side_o = side_reg;

endmodule

// File: hw/rtl/rci_sqrt_cell.sv
// one result bit of an integer square root, remainder form
`timescale 1ns / 1ps
module rci_sqrt_cell #(
    parameter int BIT = 0,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [61:0]       rem_i,
    input  logic [30:0]       root_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic [61:0]       rem_o,
    output logic [30:0]       root_o,
    output logic [SIDE_W-1:0] side_o
);
    logic [62:0]       trial;
    logic [62:0]       diff;
    logic              take;
    logic [61:0]       rem_reg;
    logic [30:0]       root_reg;
    logic [SIDE_W-1:0] side_reg;

    // (root + 2^BIT)^2 - root^2
    assign trial = (63'(root_i) << (BIT + 1)) + (63'd1 << (2 * BIT));
    assign diff  = {1'b0, rem_i} - trial;
    assign take  = {1'b0, rem_i} >= trial;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= take ? diff[61:0] : rem_i;
            root_reg <= take ? (root_i | (31'd1 << BIT)) : root_i;
            side_reg <= side_i;
        end
    end

    assign rem_o  = rem_reg;
    assign root_o = root_reg;
    assign side_o = side_reg;

endmodule

// File: hw/rtl/rci_div_cell.sv
// one quotient bit of a restoring unsigned division
`timescale 1ns / 1ps
module rci_div_cell #(
    parameter int BIT = 0,
    parameter int SIDE_W = 1
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [63:0]                  rem_i,
    input  logic [30:0]                  dvs_i,
    input  logic [rci_pkg::QUO_BITS-1:0] quo_i,
    input  logic [SIDE_W-1:0]            side_i,
    output logic [63:0]                  rem_o,
    output logic [30:0]                  dvs_o,
    output logic [rci_pkg::QUO_BITS-1:0] quo_o,
    output logic [SIDE_W-1:0]            side_o
);
    import rci_pkg::*;

    logic [64:0]         ds;
    logic [64:0]         diff;
    logic                take;
    logic [63:0]         rem_reg;
    logic [30:0]         dvs_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic [SIDE_W-1:0]   side_reg;

    assign ds   = 65'(dvs_i) << BIT;
    assign diff = {1'b0, rem_i} - ds;
    assign take = {1'b0, rem_i} >= ds;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= take ? diff[63:0] : rem_i;
            quo_reg  <= take ? (quo_i | (QUO_BITS'(1) << BIT)) : quo_i;
            dvs_reg  <= dvs_i;
            side_reg <= side_i;
        end
    end

    assign rem_o  = rem_reg;
    assign dvs_o  = dvs_reg;
    assign quo_o  = quo_reg;
    assign side_o = side_reg;

endmodule

// File: hw/rtl/ray_cylinder_intersection.sv
// top level: track start point and angles in, cylinder crossing point out
//
// Input channel s_*: start point (signed Q16.16) and polar / azimuthal angle
// codes, one track per transfer. Output channel m_*: crossing point
// (signed Q16.16, saturated) and hit flag; with no positive crossing, a
// vertical track or a miss, the start point comes back with hit_found low.
// Configuration channel cfg_*: cylinder radius (unsigned Q15.16), always
// ready; the user writes it only while no track is in flight, the block does
// not enforce this. From input transfer to output valid (rci_pkg::LAT) lie an
// input stage, a sine/cosine pipeline of 18 stages with one cell per series
// term, four plane stages, a 31-cell square root chain (one root bit per
// cell), three stages, a 34-cell divider chain for z and one output stage.
// Throughput is one track per cycle. When the receiver stalls with a result
// waiting, the whole pipeline holds and s_ready goes low in the same cycle.
// Reset (aresetn low, synchronous) empties the pipeline and sets the radius
// to 1.0.
`timescale 1ns / 1ps
module ray_cylinder_intersection #(
    parameter int ANGLE_BITS = rci_pkg::ANGLE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rci_pkg::q16_t        s_start_x,
    input  rci_pkg::q16_t        s_start_y,
    input  rci_pkg::q16_t        s_start_z,
    input  logic [15:0]          s_theta_code,
    input  logic [15:0]          s_phi_code,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rci_pkg::q16_t        m_end_x,
    output rci_pkg::q16_t        m_end_y,
    output rci_pkg::q16_t        m_end_z,
    output logic                 m_hit_found,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [30:0]          cfg_radius
);
    import rci_pkg::*;

    localparam logic [55:0] AMASK = (56'd1 << ANGLE_BITS) - 56'd1;
    localparam int SQ_W = 1 + 34 + 7 * 32;
    localparam int DV_W = 3 * 32 + 3;

    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [30:0]    radius_reg;

    // pipeline advances unless a result waits and the receiver is not ready
    assign en        = !vld_reg[LAT-1] || m_ready;
    assign s_ready   = en;
    assign m_valid   = vld_reg[LAT-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // radius register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_valid) begin
            radius_reg <= cfg_radius;
        end
    end

    // input stage: angle codes to turns
    logic [55:0] tt_w;
    logic [55:0] pt_w;
    q16_t        x0_reg;
    q16_t        y0_reg;
    q16_t        z0_reg;
    logic [31:0] tturn_reg;
    logic [31:0] pturn_reg;

    assign tt_w = ({40'd0, s_theta_code} & AMASK) << (31 - ANGLE_BITS);
    assign pt_w = ({40'd0, s_phi_code} & AMASK) << (32 - ANGLE_BITS);

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg    <= s_start_x;
            y0_reg    <= s_start_y;
            z0_reg    <= s_start_z;
            tturn_reg <= tt_w[31:0];
            pturn_reg <= pt_w[31:0];
        end
    end

    // sine and cosine of both angles
    q30_t        st;
    q30_t        ct;
    q30_t        sp;
    q30_t        cp;
    logic [63:0] th_side;
    logic [31:0] ph_side;

    rci_sincos #(.SIDE_W(64)) u_theta (
        .aclk   (aclk),
        .en     (en),
        .turns  (tturn_reg),
        .side_i ({x0_reg, y0_reg}),
        .sin_o  (st),
        .cos_o  (ct),
        .side_o (th_side)
    );

    rci_sincos #(.SIDE_W(32)) u_phi (
        .aclk   (aclk),
        .en     (en),
        .turns  (pturn_reg),
        .side_i (z0_reg),
        .sin_o  (sp),
        .cos_o  (cp),
        .side_o (ph_side)
    );

    // p1: rotation products
    logic signed [63:0] mxc_reg;
    logic signed [63:0] mys_reg;
    logic signed [63:0] myc_reg;
    logic signed [63:0] mxs_reg;
    q16_t p1_x0_reg, p1_y0_reg, p1_z0_reg;
    q30_t p1_st_reg, p1_ct_reg, p1_sp_reg, p1_cp_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mxc_reg   <= 64'($signed(th_side[63:32])) * 64'(cp);
            mys_reg   <= 64'($signed(th_side[31:0])) * 64'(sp);
            myc_reg   <= 64'($signed(th_side[31:0])) * 64'(cp);
            mxs_reg   <= 64'($signed(th_side[63:32])) * 64'(sp);
            p1_x0_reg <= th_side[63:32];
            p1_y0_reg <= th_side[31:0];
            p1_z0_reg <= ph_side;
            p1_st_reg <= st;
            p1_ct_reg <= ct;
            p1_sp_reg <= sp;
            p1_cp_reg <= cp;
        end
    end

    // p2: rotated coordinates u, w
    logic signed [33:0] u_reg;
    logic signed [33:0] w_reg;
    q16_t p2_x0_reg, p2_y0_reg, p2_z0_reg;
    q30_t p2_st_reg, p2_ct_reg, p2_sp_reg, p2_cp_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg     <= rnd30(mxc_reg + mys_reg);
            w_reg     <= rnd30(myc_reg - mxs_reg);
            p2_x0_reg <= p1_x0_reg;
            p2_y0_reg <= p1_y0_reg;
            p2_z0_reg <= p1_z0_reg;
            p2_st_reg <= p1_st_reg;
            p2_ct_reg <= p1_ct_reg;
            p2_sp_reg <= p1_sp_reg;
            p2_cp_reg <= p1_cp_reg;
        end
    end

    // p3: squares of radius and |w|, discriminant sign
    logic signed [33:0] w_abs_s;
    logic [32:0]        aw;
    logic               ok_reg;
    logic [61:0]        rsq_reg;
    logic [61:0]        awsq_reg;
    logic signed [33:0] p3_u_reg;
    q16_t p3_x0_reg, p3_y0_reg, p3_z0_reg;
    q30_t p3_st_reg, p3_ct_reg, p3_sp_reg, p3_cp_reg;

    assign w_abs_s = w_reg[33] ? -w_reg : w_reg;
    assign aw      = w_abs_s[32:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            ok_reg    <= (p2_st_reg > 32'sd0) && (aw <= {2'b00, radius_reg});
            rsq_reg   <= 62'(radius_reg) * 62'(radius_reg);
            awsq_reg  <= 62'(aw[30:0]) * 62'(aw[30:0]);
            p3_u_reg  <= u_reg;
            p3_x0_reg <= p2_x0_reg;
            p3_y0_reg <= p2_y0_reg;
            p3_z0_reg <= p2_z0_reg;
            p3_st_reg <= p2_st_reg;
            p3_ct_reg <= p2_ct_reg;
            p3_sp_reg <= p2_sp_reg;
            p3_cp_reg <= p2_cp_reg;
        end
    end

    // p4: discriminant
    logic [61:0]     dd_reg;
    logic [SQ_W-1:0] p4_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dd_reg      <= rsq_reg - awsq_reg;
            p4_side_reg <= {ok_reg, p3_u_reg, p3_x0_reg, p3_y0_reg, p3_z0_reg,
                            p3_st_reg, p3_ct_reg, p3_sp_reg, p3_cp_reg};
        end
    end

    // square root chain, one root bit per cell
    logic [61:0]     sq_rem [0:SQRT_BITS];
    logic [30:0]     sq_root [0:SQRT_BITS];
    logic [SQ_W-1:0] sq_side [0:SQRT_BITS];

    assign sq_rem[0]  = dd_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = p4_side_reg;

    for (genvar g = 0; g < SQRT_BITS; g++) begin : g_sqrt
        rci_sqrt_cell #(.BIT(SQRT_BITS - 1 - g), .SIDE_W(SQ_W)) u_cell (
            .aclk   (aclk),
            .en     (en),
            .rem_i  (sq_rem[g]),
            .root_i (sq_root[g]),
            .side_i (sq_side[g]),
            .rem_o  (sq_rem[g+1]),
            .root_o (sq_root[g+1]),
            .side_o (sq_side[g+1])
        );
    end

    // p5: roots of the plane quadratic, pick the first positive one
    logic               s_ok;
    logic signed [33:0] s_u;
    q16_t s_x0, s_y0, s_z0;
    q30_t s_st, s_ct, s_sp, s_cp;
    logic signed [34:0] nu;
    logic signed [34:0] qs;
    logic signed [34:0] d1;
    logic signed [34:0] d2;
    logic signed [34:0] d_reg;
    logic               p5_hit_reg;
    q16_t p5_x0_reg, p5_y0_reg, p5_z0_reg;
    q30_t p5_st_reg, p5_ct_reg, p5_sp_reg, p5_cp_reg;

    assign {s_ok, s_u, s_x0, s_y0, s_z0, s_st, s_ct, s_sp, s_cp} = sq_side[SQRT_BITS];
    assign nu = -35'(s_u);
    assign qs = $signed({4'd0, sq_root[SQRT_BITS]});
    assign d1 = nu - qs;
    assign d2 = nu + qs;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg      <= (d1 > 35'sd0) ? d1 : d2;
            p5_hit_reg <= s_ok && ((d1 > 35'sd0) || (d2 > 35'sd0));
            p5_x0_reg  <= s_x0;
            p5_y0_reg  <= s_y0;
            p5_z0_reg  <= s_z0;
            p5_st_reg  <= s_st;
            p5_ct_reg  <= s_ct;
            p5_sp_reg  <= s_sp;
            p5_cp_reg  <= s_cp;
        end
    end

    // p6: step along the track
    logic signed [63:0] dcp_reg;
    logic signed [63:0] dsp_reg;
    logic signed [63:0] num_reg;
    logic               p6_hit_reg;
    q16_t p6_x0_reg, p6_y0_reg, p6_z0_reg;
    q30_t p6_st_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dcp_reg    <= 64'(d_reg) * 64'(p5_cp_reg);
            dsp_reg    <= 64'(d_reg) * 64'(p5_sp_reg);
            num_reg    <= 64'(d_reg) * 64'(p5_ct_reg);
            p6_hit_reg <= p5_hit_reg;
            p6_x0_reg  <= p5_x0_reg;
            p6_y0_reg  <= p5_y0_reg;
            p6_z0_reg  <= p5_z0_reg;
            p6_st_reg  <= p5_st_reg;
        end
    end

    // p7: x and y end points, set up the z division
    logic signed [63:0] num_abs;
    logic               big;
    q16_t               ex;
    q16_t               ey;
    logic [63:0]        mag_reg;
    logic [30:0]        dvs_reg;
    logic [DV_W-1:0]    p7_side_reg;

    assign num_abs = num_reg[63] ? -num_reg : num_reg;
    assign big     = {2'b00, num_abs} >= (66'(p6_st_reg[30:0]) << QUO_BITS);
    assign ex      = p6_hit_reg ? sat32(40'(p6_x0_reg) + 40'(rnd30(dcp_reg))) : p6_x0_reg;
    assign ey      = p6_hit_reg ? sat32(40'(p6_y0_reg) + 40'(rnd30(dsp_reg))) : p6_y0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg     <= num_abs;
            dvs_reg     <= p6_st_reg[30:0];
            p7_side_reg <= {ex, ey, p6_z0_reg, p6_hit_reg, num_reg[63], big};
        end
    end

    // divider chain, one quotient bit per cell
    logic [63:0]         dv_rem [0:QUO_BITS];
    logic [30:0]         dv_dvs [0:QUO_BITS];
    logic [QUO_BITS-1:0] dv_quo [0:QUO_BITS];
    logic [DV_W-1:0]     dv_side [0:QUO_BITS];

    assign dv_rem[0]  = mag_reg;
    assign dv_dvs[0]  = dvs_reg;
    assign dv_quo[0]  = '0;
    assign dv_side[0] = p7_side_reg;

    for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
        rci_div_cell #(.BIT(QUO_BITS - 1 - g), .SIDE_W(DV_W)) u_cell (
            .aclk   (aclk),
            .en     (en),
            .rem_i  (dv_rem[g]),
            .dvs_i  (dv_dvs[g]),
            .quo_i  (dv_quo[g]),
            .side_i (dv_side[g]),
            .rem_o  (dv_rem[g+1]),
            .dvs_o  (dv_dvs[g+1]),
            .quo_o  (dv_quo[g+1]),
            .side_o (dv_side[g+1])
        );
    end

    // output stage: z end point and saturation
    q16_t               f_ex;
    q16_t               f_ey;
    q16_t               f_z0;
    logic               f_hit;
    logic               f_neg;
    logic               f_big;
    logic signed [35:0] dz;
    q16_t               ez;
    q16_t               end_x_reg;
    q16_t               end_y_reg;
    q16_t               end_z_reg;
    logic               hit_reg;

    assign {f_ex, f_ey, f_z0, f_hit, f_neg, f_big} = dv_side[QUO_BITS];
    assign dz = f_neg ? -$signed({2'b00, dv_quo[QUO_BITS]})
                      : $signed({2'b00, dv_quo[QUO_BITS]});

    always_comb begin
        if (!f_hit) begin
            ez = f_z0;
        end else if (f_big) begin
            ez = f_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            ez = sat32(40'(f_z0) + 40'(dz));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            end_x_reg <= f_ex;
            end_y_reg <= f_ey;
            end_z_reg <= ez;
            hit_reg   <= f_hit;
        end
    end

    assign m_end_x     = end_x_reg;
    assign m_end_y     = end_y_reg;
    assign m_end_z     = end_z_reg;
    assign m_hit_found = hit_reg;

endmodule

// File: hw/rtl/rci_checker.sv
// port-level checks of the ray cylinder intersection and their binding
`timescale 1ns / 1ps
`include "ray_cylinder_intersection_assert.svh"
module rci_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input rci_pkg::q16_t m_end_x,
    input rci_pkg::q16_t m_end_y,
    input rci_pkg::q16_t m_end_z,
    input logic          m_hit_found,
    input logic          cfg_ready
);
    logic [96:0] m_payload;

    assign m_payload = {m_end_x, m_end_y, m_end_z, m_hit_found};

    // a stalled result stays
    `RCI_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid)
    // a stalled result keeps its payload
    `RCI_ASSERT(a_out_stable, m_valid && !m_ready |=> $stable(m_payload))
    // input is taken exactly when the pipeline can move
    `RCI_ASSERT(a_ready_flow, s_ready == (!m_valid || m_ready))
    // reset empties the pipeline, config stays open
    `RCI_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid && cfg_ready)
endmodule

bind ray_cylinder_intersection rci_checker u_rci_checker (.*);

// File: sim/ray_cylinder_intersection_tb.sv
// self-checking testbench of the ray cylinder intersection block
`timescale 1ns / 1ps
module ray_cylinder_intersection_tb;

    localparam int ANGLE_BITS = rci_pkg::ANGLE_BITS_DEF;
    localparam int PIPE_DEPTH = rci_pkg::LAT;
    localparam logic [30:0] RADIUS_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        theta;
        logic [15:0]        phi;
    } track_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               hit;
    } crossing_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_start_x = '0, s_start_y = '0, s_start_z = '0;
    logic [15:0] s_theta_code = '0, s_phi_code = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_end_x, m_end_y, m_end_z;
    logic m_hit_found;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [30:0] cfg_radius = '0;

    track_t    track_q[$];
    crossing_t crossing_q[$];
    logic [30:0] radius_model = rci_pkg::RADIUS_RESET;
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    logic hold_start = 1'b0;

    ray_cylinder_intersection #(.ANGLE_BITS(ANGLE_BITS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_x(s_start_x), .s_start_y(s_start_y), .s_start_z(s_start_z),
        .s_theta_code(s_theta_code), .s_phi_code(s_phi_code),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_end_x(m_end_x), .m_end_y(m_end_y), .m_end_z(m_end_z),
        .m_hit_found(m_hit_found),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_radius(cfg_radius)
    );

    always #10 aclk = ~aclk;

    // signed division truncating toward zero via magnitudes
    function automatic longint div_trunc(input longint n, input longint d);
        longint m;
        m = longint'(64'(n < 0 ? -n : n) / 64'(d));
        return (n < 0) ? -m : m;
    endfunction

    function automatic longint round_q30(input longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint root_floor(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // octant-folded horner series, Q30 sine and cosine of a 32-bit turn
    task automatic angle_sincos(input logic [31:0] turns, output longint s,
                                output longint c);
        int ks [6] = '{156, 110, 72, 42, 20, 6};
        int kc [7] = '{182, 132, 90, 56, 30, 12, 2};
        logic [2:0] oct;
        logic [63:0] r, xv, x2, ts, tc, sv, cv, tmp;
        oct = turns[31:29];
        r = {35'd0, turns[28:0]};
        if (oct[0]) r = 64'h2000_0000 - r;
        xv = (r * 64'd6746518852) >> 32;
        x2 = (xv * xv) >> 30;
        ts = 64'd1 << 30;
        tc = 64'd1 << 30;
        for (int i = 0; i < 6; i++) ts = (64'd1 << 30) - ((x2 * ts) >> 30) / ks[i];
        for (int i = 0; i < 7; i++) tc = (64'd1 << 30) - ((x2 * tc) >> 30) / kc[i];
        sv = (xv * ts) >> 30;
        cv = tc;
        if ((((oct + 4'd1) >> 1) & 1) != 0) begin
            tmp = sv; sv = cv; cv = tmp;
        end
        s = (oct >= 4) ? -longint'(sv) : longint'(sv);
        c = (oct >= 2 && oct <= 5) ? -longint'(cv) : longint'(cv);
    endtask

    task automatic predict_crossing(input track_t t, output crossing_t res);
        longint st, ct, sp, cp, u, w, q, d1, d2, d, aw, x0, y0, z0;
        logic [31:0] tturn, pturn;
        logic [63:0] dd;
        x0 = t.x; y0 = t.y; z0 = t.z;
        tturn = 32'(t.theta[ANGLE_BITS-1:0]) << (31 - ANGLE_BITS);
        pturn = 32'(t.phi[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
        angle_sincos(tturn, st, ct);
        angle_sincos(pturn, sp, cp);
        res = '{x: t.x, y: t.y, z: t.z, hit: 1'b0};
        if (st > 0) begin
            u = round_q30(x0 * cp + y0 * sp);
            w = round_q30(y0 * cp - x0 * sp);
            aw = (w < 0) ? -w : w;
            if (aw <= longint'(radius_model)) begin
                dd = 64'(radius_model) * 64'(radius_model) - 64'(aw) * 64'(aw);
                q = root_floor(dd);
                d1 = -u - q;
                d2 = -u + q;
                d = 0;
                if (d1 > 0) begin
                    d = d1; res.hit = 1'b1;
                end else if (d2 > 0) begin
                    d = d2; res.hit = 1'b1;
                end
                if (res.hit) begin
                    res.x = 32'(clamp32(x0 + round_q30(d * cp)));
                    res.y = 32'(clamp32(y0 + round_q30(d * sp)));
                    res.z = 32'(clamp32(z0 + div_trunc(d * ct, st)));
                end
            end
        end
    endtask

    // driver: offer the queue head, predict on transfer
    always @(posedge aclk) begin
        crossing_t exp_res;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_crossing(track_q.pop_front(), exp_res);
                crossing_q.push_back(exp_res);
            end
            if ((!s_valid || s_ready) && track_q.size() > 0 &&
                    ($urandom_range(99) >= send_idle_pct)) begin
                s_valid <= 1'b1;
                s_start_x <= track_q[0].x;
                s_start_y <= track_q[0].y;
                s_start_z <= track_q[0].z;
                s_theta_code <= track_q[0].theta;
                s_phi_code <= track_q[0].phi;
            end else if (s_ready) begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off counter
    always @(posedge aclk) begin
        if (hold_start) begin
            hold_cycles <= 3 * PIPE_DEPTH;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        crossing_t exp_res;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (crossing_q.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d hit=%0b", $time,
                             m_end_x, m_end_y, m_end_z, m_hit_found);
                    errors++;
                end else begin
                    exp_res = crossing_q.pop_front();
                    if (m_end_x !== exp_res.x) begin
                        $display("%0t: end_x exp %0d got %0d", $time, exp_res.x, m_end_x);
                        errors++;
                    end
                    if (m_end_y !== exp_res.y) begin
                        $display("%0t: end_y exp %0d got %0d", $time, exp_res.y, m_end_y);
                        errors++;
                    end
                    if (m_end_z !== exp_res.z) begin
                        $display("%0t: end_z exp %0d got %0d", $time, exp_res.z, m_end_z);
                        errors++;
                    end
                    if (m_hit_found !== exp_res.hit) begin
                        $display("%0t: hit_found exp %0b got %0b", $time, exp_res.hit,
                                 m_hit_found);
                        errors++;
                    end
                end
            end
            if (hold_start || hold_cycles > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic add_track(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [15:0] th,
                             input logic [15:0] ph);
        track_q.push_back('{x: x, y: y, z: z, theta: th, phi: ph});
    endtask

    // mostly tracks near the cylinder, with some full-range noise
    task automatic add_random(input int n);
        logic [31:0] span;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 2) begin
                add_track($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom));
            end else begin
                span = 32'(radius_model) * 2 + 32'd65536;
                if (span > 32'h7FFF_0000 || span == 0) span = 32'h7FFF_0000;
                add_track(32'($signed($urandom_range(span)) - $signed(span >> 1)),
                          32'($signed($urandom_range(span)) - $signed(span >> 1)),
                          $urandom_range(32'h0400_0000) - 32'h0200_0000,
                          16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic drain_pipe();
        while (track_q.size() > 0 || s_valid || crossing_q.size() > 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 10) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [30:0] r);
        cfg_valid <= 1'b1;
        cfg_radius <= r;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        radius_model = r;
    endtask

    // stimulus phases
    initial begin
        logic [30:0] radii [5];
        radii = '{31'd65536, 31'd0, RADIUS_MAX, 31'd1, 31'h0050_0000};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: vertical, miss, tangent, outward / inward, saturation, bit toggles
        add_track(0, 0, 0, 16'h0000, 16'h0000);
        add_track(32'h0002_0000, 0, 0, 16'h8000, 16'h4000);
        add_track(32'h0001_0000, 32'h0005_0000, 0, 16'h8000, 16'h0000);
        add_track(0, 32'h0001_0000, 0, 16'h8000, 16'h0000);
        add_track(0, 0, 32'h0001_0000, 16'h4000, 16'h2000);
        add_track(32'h0003_0000, 0, 0, 16'h8000, 16'h8000);
        add_track(32'h0003_0000, 0, 0, 16'h8000, 16'h0000);
        add_track(0, 0, 32'h7FFF_FFFF, 16'h0001, 16'h1234);
        add_track(0, 0, 32'h8000_0000, 16'hFFFF, 16'hFFFF);
        add_track(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16'h8000, 16'h6000);
        add_track(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'hE000);
        add_track(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hAAAA, 16'h5555);
        add_track(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555, 16'hAAAA);
        add_track(0, 0, 0, 16'h7FFF, 16'hC000);
        drain_pipe();
        for (int ph = 0; ph < 5; ph++) begin
            write_radius(radii[ph]);
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 55; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 55; end
                3: begin send_idle_pct = 35; recv_stall_pct = 35; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            add_random(120);
            // long receiver hold-off so the pipeline fills and stalls the input
            if (ph == 4) begin
                hold_start <= 1'b1;
                @(posedge aclk);
                hold_start <= 1'b0;
            end
            drain_pipe();
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
